// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the key/value parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
    else $error(msg);

// Condition that must hold in the cycle after a trigger.
`define ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/ktx2kv_pkg.sv =====
// Shared types, constants and helper functions of the key/value parser.
`default_nettype none

package ktx2kv_pkg;

  // Largest block that is parsed; longer blocks are ignored.
  localparam logic [19:0] MAX_BLOCK_BYTES = 20'd524288;

  // Orientation key length and register index.
  localparam logic [3:0] KEY_LEN          = 4'd14;
  localparam logic       REG_BLOCK_LENGTH = 1'b0;

  localparam logic [7:0] CHAR_L = 8'h6C;
  localparam logic [7:0] CHAR_U = 8'h75;

  typedef enum logic [1:0] {
    KIND_RECORD = 2'd0,
    KIND_ERROR  = 2'd1,
    KIND_END    = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_SIZE_SMALL = 3'd1,
    ERR_RANGE      = 3'd2,
    ERR_KEY_TERM   = 3'd3,
    ERR_VALUE_TERM = 3'd4
  } err_e;

  // Lower-case form of "KTXorientation", one character per index.
  function automatic logic [7:0] orient_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = 8'h6B; // k
      4'd1:    c = 8'h74; // t
      4'd2:    c = 8'h78; // x
      4'd3:    c = 8'h6F; // o
      4'd4:    c = 8'h72; // r
      4'd5:    c = 8'h69; // i
      4'd6:    c = 8'h65; // e
      4'd7:    c = 8'h6E; // n
      4'd8:    c = 8'h74; // t
      4'd9:    c = 8'h61; // a
      4'd10:   c = 8'h74; // t
      4'd11:   c = 8'h69; // i
      4'd12:   c = 8'h6F; // o
      4'd13:   c = 8'h6E; // n
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // ASCII upper case to lower case, everything else unchanged.
  function automatic logic [7:0] lower_ascii(input logic [7:0] c);
    logic [7:0] r;
    r = ((c >= 8'h41) && (c <= 8'h5A)) ? (c + 8'd32) : c;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ktx2_key_value_parser_top.sv =====
// Key/value block parser: byte stream in, one record/error/end report out.
//
//  channel   | dir | transfer when               | content
//  ----------+-----+-----------------------------+----------------------------------
//  s_axis    | in  | s_axis_tvalid_i & tready_o  | one byte of the key/value block
//  m_axis    | out | m_axis_tvalid_o & tready_i  | report; tuser=kind, tlast=block end
//  apb       | in  | psel & penable & pwrite     | block_length, restarts the parse
//
// One byte per clock while input is ready: each byte updates the parse counters
// and any report is registered in the same cycle, into the output or skid entry.
// A two-entry output (register plus skid) keeps input ready registered; input
// stalls only when both output entries are full.
// Reset and each block_length write put the parse back to the size word.
// Bytes beyond block_length, or for an empty or oversized block, are dropped.
`default_nettype none

module ktx2_key_value_parser_top
  import ktx2kv_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  // output stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [2:0] error_code, [21:3] record_offset, [40:22] key_length,
  // [59:41] value_length, [60] is_orientation, [61] flip_h, [62] flip_v, [63] zero
  output logic [63:0]      m_axis_tdata_o,
  output logic [1:0]       m_axis_tuser_o,   // [1:0] kind
  output logic             m_axis_tlast_o,   // block_done
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  typedef enum logic [1:0] {
    PH_SIZE  = 2'd0,
    PH_KEY   = 2'd1,
    PH_VALUE = 2'd2,
    PH_PAD   = 2'd3
  } phase_e;

  typedef struct packed {
    kind_e       kind;
    err_e        err;
    logic [18:0] offset;
    logic [18:0] klen;
    logic [18:0] vlen;
    logic        is_or;
    logic        flip_h;
    logic        flip_v;
    logic        last;
  } rep_t;

  // Configuration and parse state
  logic [19:0] blk_len_q;
  phase_e      phase_q, phase_d;
  logic [19:0] pos_q, pos_d;
  logic [1:0]  sz_cnt_q, sz_cnt_d;
  logic [23:0] rsize_q, rsize_d;
  logic [19:0] rem_q, rem_d;
  logic [19:0] rstart_q, rstart_d;
  logic [19:0] kcnt_q, kcnt_d;
  logic [19:0] vcnt_q, vcnt_d;
  logic [3:0]  midx_q, midx_d;
  logic        malive_q, malive_d;
  logic        fv_l_q, fv_l_d;
  logic        fv_nz_q, fv_nz_d;
  logic        sec_u_q, sec_u_d;
  logic [1:0]  pad_q, pad_d;
  logic        ofound_q, ofound_d;
  logic        fliph_q, fliph_d;
  logic        flipv_q, flipv_d;
  logic        stop_q, stop_d;

  // Output register and skid entry
  rep_t        out_q, skid_q;
  logic        out_vq, skid_vq;
  rep_t        rep;
  logic        rep_valid;

  logic        cfg_we;
  logic        in_xfer;
  logic        active;
  logic        last;
  logic [19:0] start;
  logic [31:0] full_size;
  logic [19:0] avail;
  logic [19:0] rem_dec;
  logic [7:0]  b;

  // APB access
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_BLOCK_LENGTH);
  assign prdata = (paddr[2] == REG_BLOCK_LENGTH) ? {12'd0, blk_len_q} : 32'd0;

  // Byte qualification
  assign s_axis_tready_o = !skid_vq;
  assign in_xfer   = s_axis_tvalid_i && s_axis_tready_o;
  assign active    = in_xfer && (blk_len_q != 20'd0) && (blk_len_q <= MAX_BLOCK_BYTES)
                     && (pos_q < blk_len_q);
  assign last      = (pos_q == (blk_len_q - 20'd1));
  assign start     = pos_q + 20'd1;
  assign b         = s_axis_tdata_i;
  assign full_size = {b, rsize_q};
  assign avail     = blk_len_q - start;
  assign rem_dec   = rem_q - 20'd1;

  // Per-byte parse step
  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    sz_cnt_d  = sz_cnt_q;
    rsize_d   = rsize_q;
    rem_d     = rem_q;
    rstart_d  = rstart_q;
    kcnt_d    = kcnt_q;
    vcnt_d    = vcnt_q;
    midx_d    = midx_q;
    malive_d  = malive_q;
    fv_l_d    = fv_l_q;
    fv_nz_d   = fv_nz_q;
    sec_u_d   = sec_u_q;
    pad_d     = pad_q;
    ofound_d  = ofound_q;
    fliph_d   = fliph_q;
    flipv_d   = flipv_q;
    stop_d    = stop_q;
    rep_valid = 1'b0;
    rep.kind   = KIND_END;
    rep.err    = ERR_NONE;
    rep.offset = 19'd0;
    rep.klen   = 19'd0;
    rep.vlen   = 19'd0;
    rep.is_or  = 1'b0;

    if (active) begin
      pos_d = start;
      if (!stop_q) begin
        unique case (phase_q)
          PH_SIZE: begin
            // little-endian size word, fourth byte taken straight from the input
            sz_cnt_d = sz_cnt_q + 2'd1;
            unique case (sz_cnt_q)
              2'd0:    rsize_d[7:0]   = b;
              2'd1:    rsize_d[15:8]  = b;
              2'd2:    rsize_d[23:16] = b;
              default: rsize_d        = rsize_q;
            endcase
            if (sz_cnt_q == 2'd3) begin
              if (full_size < 32'd2) begin
                rep.kind   = KIND_ERROR;
                rep.err    = ERR_SIZE_SMALL;
                rep.offset = start[18:0];
              end else if (full_size > {12'd0, avail}) begin
                rep.kind   = KIND_ERROR;
                rep.err    = ERR_RANGE;
                rep.offset = start[18:0];
              end else begin
                rstart_d = start;
                rem_d    = full_size[19:0];
                kcnt_d   = 20'd0;
                vcnt_d   = 20'd0;
                midx_d   = 4'd0;
                malive_d = 1'b1;
                fv_l_d   = 1'b0;
                fv_nz_d  = 1'b0;
                sec_u_d  = 1'b0;
                phase_d  = PH_KEY;
              end
            end else if (last) begin
              // block ends inside the size word
              rep.kind   = KIND_ERROR;
              rep.err    = ERR_RANGE;
              rep.offset = pos_q[18:0] + 19'd4 - {17'd0, sz_cnt_q};
            end
          end
          PH_KEY: begin
            rem_d = rem_dec;
            if (b == 8'd0) begin
              malive_d = malive_q && (midx_q == KEY_LEN);
              if (rem_dec == 20'd0) begin
                rep.kind   = KIND_ERROR;
                rep.err    = ERR_VALUE_TERM;
                rep.offset = rstart_q[18:0];
              end else begin
                phase_d = PH_VALUE;
              end
            end else begin
              kcnt_d = kcnt_q + 20'd1;
              if (rem_dec == 20'd0) begin
                rep.kind   = KIND_ERROR;
                rep.err    = ERR_KEY_TERM;
                rep.offset = rstart_q[18:0];
              end else if (malive_q && (midx_q < KEY_LEN)
                           && (lower_ascii(b) == orient_char(midx_q))) begin
                midx_d = midx_q + 4'd1;
              end else begin
                malive_d = 1'b0;
              end
            end
          end
          PH_VALUE: begin
            rem_d = rem_dec;
            if (rem_dec == 20'd0) begin
              if (b != 8'd0) begin
                rep.kind   = KIND_ERROR;
                rep.err    = ERR_VALUE_TERM;
                rep.offset = rstart_q[18:0];
              end else begin
                // record complete
                rep_valid  = 1'b1;
                rep.kind   = KIND_RECORD;
                rep.offset = rstart_q[18:0];
                rep.klen   = kcnt_q[18:0];
                rep.vlen   = vcnt_q[18:0];
                rep.is_or  = malive_q;
                if (malive_q && !ofound_q) begin
                  ofound_d = 1'b1;
                  fliph_d  = fv_l_q;
                  flipv_d  = fv_nz_q && sec_u_q;
                end
                pad_d   = 2'd0 - rsize_q[1:0];
                phase_d = (pad_d != 2'd0) ? PH_PAD : PH_SIZE;
              end
            end else if (b == 8'd0) begin
              rep.kind   = KIND_ERROR;
              rep.err    = ERR_VALUE_TERM;
              rep.offset = rstart_q[18:0];
            end else begin
              if (vcnt_q == 20'd0) begin
                fv_l_d  = (b == CHAR_L);
                fv_nz_d = 1'b1;
              end else if (vcnt_q == 20'd1) begin
                sec_u_d = (b == CHAR_U);
              end
              vcnt_d = vcnt_q + 20'd1;
            end
          end
          PH_PAD: begin
            if (pad_q != 2'd0) begin
              pad_d = pad_q - 2'd1;
            end
            if (pad_d == 2'd0) begin
              phase_d = PH_SIZE;
            end
          end
          default: phase_d = PH_SIZE;
        endcase
        if (rep.kind == KIND_ERROR) begin
          rep_valid = 1'b1;
          stop_d    = 1'b1;
        end
      end
      if (last) begin
        rep_valid = 1'b1;
      end
    end
    rep.flip_h = fliph_d;
    rep.flip_v = flipv_d;
    rep.last   = last;
  end

  // Parse state; a block_length write restarts the parse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_len_q <= 20'd0;
      phase_q   <= PH_SIZE;
      pos_q     <= 20'd0;
      sz_cnt_q  <= 2'd0;
      rsize_q   <= 24'd0;
      rem_q     <= 20'd0;
      rstart_q  <= 20'd0;
      kcnt_q    <= 20'd0;
      vcnt_q    <= 20'd0;
      midx_q    <= 4'd0;
      malive_q  <= 1'b1;
      fv_l_q    <= 1'b0;
      fv_nz_q   <= 1'b0;
      sec_u_q   <= 1'b0;
      pad_q     <= 2'd0;
      ofound_q  <= 1'b0;
      fliph_q   <= 1'b0;
      flipv_q   <= 1'b1;
      stop_q    <= 1'b0;
    end else if (cfg_we) begin
      blk_len_q <= pwdata[19:0];
      phase_q   <= PH_SIZE;
      pos_q     <= 20'd0;
      sz_cnt_q  <= 2'd0;
      rsize_q   <= 24'd0;
      rem_q     <= 20'd0;
      rstart_q  <= 20'd0;
      kcnt_q    <= 20'd0;
      vcnt_q    <= 20'd0;
      midx_q    <= 4'd0;
      malive_q  <= 1'b1;
      fv_l_q    <= 1'b0;
      fv_nz_q   <= 1'b0;
      sec_u_q   <= 1'b0;
      pad_q     <= 2'd0;
      ofound_q  <= 1'b0;
      fliph_q   <= 1'b0;
      flipv_q   <= 1'b1;
      stop_q    <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      sz_cnt_q  <= sz_cnt_d;
      rsize_q   <= rsize_d;
      rem_q     <= rem_d;
      rstart_q  <= rstart_d;
      kcnt_q    <= kcnt_d;
      vcnt_q    <= vcnt_d;
      midx_q    <= midx_d;
      malive_q  <= malive_d;
      fv_l_q    <= fv_l_d;
      fv_nz_q   <= fv_nz_d;
      sec_u_q   <= sec_u_d;
      pad_q     <= pad_d;
      ofound_q  <= ofound_d;
      fliph_q   <= fliph_d;
      flipv_q   <= flipv_d;
      stop_q    <= stop_d;
    end
  end

  // Output valid flags: main register refills from skid first
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vq  <= 1'b0;
      skid_vq <= 1'b0;
    end else if (!out_vq || m_axis_tready_i) begin
      out_vq  <= skid_vq || rep_valid;
      skid_vq <= 1'b0;
    end else if (rep_valid) begin
      skid_vq <= 1'b1;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (!out_vq || m_axis_tready_i) begin
      out_q <= skid_vq ? skid_q : rep;
    end else if (rep_valid) begin
      skid_q <= rep;
    end
  end

  assign m_axis_tvalid_o = out_vq;
  assign m_axis_tuser_o  = out_q.kind;
  assign m_axis_tlast_o  = out_q.last;
  assign m_axis_tdata_o  = {1'b0, out_q.flip_v, out_q.flip_h, out_q.is_or,
                            out_q.vlen, out_q.klen, out_q.offset, out_q.err};

endmodule

`default_nettype wire

// ===== rtl/ktx2kv_checker.sv =====
// Port-level checks of the key/value parser and their bind to the top level.
`default_nettype none
`include "assert_macros.svh"

module ktx2kv_checker
  import ktx2kv_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [63:0] m_axis_tdata_o,
  input wire logic [1:0]  m_axis_tuser_o,
  input wire logic        m_axis_tlast_o
);

  logic out_stall;
  logic is_record;
  logic is_error;
  logic is_end;
  logic err_none;

  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;
  assign is_record = m_axis_tvalid_o && (m_axis_tuser_o == KIND_RECORD);
  assign is_error  = m_axis_tvalid_o && (m_axis_tuser_o == KIND_ERROR);
  assign is_end    = m_axis_tvalid_o && (m_axis_tuser_o == KIND_END);
  assign err_none  = (m_axis_tdata_o[2:0] == ERR_NONE);

  // a stalled report holds
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o), "stalled report changed")

  // no report directly follows a taken end-of-block report
  `ASSERT_NEXT(a_end_quiet, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o, !m_axis_tvalid_o, "report after block end")

  // record reports carry no error code
  `ASSERT_ALWAYS(a_record_ok, clk_i, rst_ni, !is_record || err_none, "record with error code")

  // error reports carry a code and no lengths
  `ASSERT_ALWAYS(a_error_fields, clk_i, rst_ni, !is_error || (!err_none && (m_axis_tdata_o[60:22] == 39'd0)), "bad error report fields")

  // end-only reports close the block and carry nothing but the flip flags
  `ASSERT_ALWAYS(a_end_fields, clk_i, rst_ni, !is_end || (m_axis_tlast_o && (m_axis_tdata_o[60:0] == 61'd0)), "bad end report fields")

endmodule

bind ktx2_key_value_parser_top ktx2kv_checker u_ktx2kv_checker (.*);

`default_nettype wire
